// ===== design/gffc_pkg.sv =====
// Package for the greedy first-fit colouring block.
// Holds field widths, action codes and the controller/datapath interface structs.
// Depends on nothing.
package gffc_pkg;

	// Fixed widths of the item fields.
	localparam int unsigned ID_W     = 10;
	localparam int unsigned COLOR_W  = 7;
	localparam int unsigned ACTION_W = 2;

	// Action codes carried by an input item.
	localparam logic [ACTION_W-1:0] ACT_NEIGHBOR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ASSIGN   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_READ     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic mem_rd;     // capture the item and read the colour store
		logic sel_nid;    // read address comes from the neighbour id
		logic sweep_wr;   // write zero at the sweep address and advance it
		logic mark;       // mark the read colour in the used-colour bitmap
		logic commit;     // store the first free colour, load it out, clear bitmap
		logic load_read;  // load the read colour into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last; // sweep address is at the last vertex
		logic out_free;   // output register can take a result this cycle
	} sts_t;

endpackage

// ===== design/gffc_ctrl.sv =====
// Controller state machine for the greedy first-fit colouring block.
// Depends on gffc_pkg; drives the datapath in gffc_dpath through cmd_t.
module gffc_ctrl import gffc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [ACTION_W-1:0] action,
	output logic                in_ready,
	input  sts_t                sts,
	output cmd_t                cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0]          state_q;
	logic [1:0]          state_d;
	logic [ACTION_W-1:0] action_q;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.mem_rd  = 1'b1;
					cmd.sel_nid = (action == ACT_NEIGHBOR);
					state_d     = (action == ACT_CLEAR) ? S_CLEAR : S_EXEC;
				end
			end
			S_EXEC: begin
				case (action_q)
					ACT_NEIGHBOR: begin
						cmd.mark = 1'b1;
						state_d  = S_IDLE;
					end
					ACT_ASSIGN: begin
						if (sts.out_free) begin
							cmd.commit = 1'b1;
							state_d    = S_IDLE;
						end
					end
					ACT_READ: begin
						if (sts.out_free) begin
							cmd.load_read = 1'b1;
							state_d       = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing sweep of the colour store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			action_q <= ACT_NEIGHBOR;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				action_q <= action;
			end
		end
	end

endmodule

// ===== design/gffc_dpath.sv =====
// Datapath of the greedy first-fit colouring block: colour store, used-colour
// bitmap, first-free search, clearing sweep counter and output register.
// Depends on gffc_pkg; commanded by gffc_ctrl.
module gffc_dpath import gffc_pkg::*; #(
	parameter int unsigned VERTEX_COUNT = 1024,
	parameter int unsigned MAX_COLORS   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ID_W-1:0]    neighbor_id,
	input  logic [ID_W-1:0]    vertex_id,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] color,
	output logic [ID_W-1:0]    vertex_out
);

	localparam int unsigned AW  = $clog2(VERTEX_COUNT);
	localparam int unsigned CW  = $clog2(MAX_COLORS + 1);
	localparam int unsigned CBW = $clog2(MAX_COLORS);

	logic [CW-1:0]         color_mem_q [VERTEX_COUNT];
	logic [CW-1:0]         rdata_q;
	logic [ID_W-1:0]       vid_q;
	logic                  inr_q;
	logic                  vinr_q;
	logic [MAX_COLORS-1:0] used_q;
	logic [AW-1:0]         sweep_q;
	logic                  out_valid_q;
	logic [COLOR_W-1:0]    color_q;
	logic [ID_W-1:0]       vertex_q;

	logic                  nid_ok;
	logic                  vid_ok;
	logic [AW-1:0]         rd_addr;
	logic                  mem_we;
	logic [AW-1:0]         wr_addr;
	logic [CW-1:0]         wr_data;
	logic [CW-1:0]         color_eff;
	logic [MAX_COLORS:0]   used_ext;
	logic [MAX_COLORS:0]   free_onehot;
	logic [CW-1:0]         free_color;

	// Ids beyond the store read as colour 0 and are never written.
	assign nid_ok  = (32'(neighbor_id) < VERTEX_COUNT);
	assign vid_ok  = (32'(vertex_id) < VERTEX_COUNT);
	assign rd_addr = cmd.sel_nid ? AW'(neighbor_id) : AW'(vertex_id);

	// The sweep owns the write port while it runs; otherwise an assign writes.
	assign mem_we  = cmd.sweep_wr | (cmd.commit & vinr_q);
	assign wr_addr = cmd.sweep_wr ? sweep_q : AW'(vid_q);
	assign wr_data = cmd.sweep_wr ? '0 : free_color;

	// Colour store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			color_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rdata_q <= color_mem_q[rd_addr];
		end
	end

	// Item fields kept for the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			vid_q  <= vertex_id;
			inr_q  <= cmd.sel_nid ? nid_ok : vid_ok;
			vinr_q <= vid_ok;
		end
	end

	assign color_eff = inr_q ? rdata_q : '0;

	// Lowest clear bit of the bitmap: one add isolates it as a one-hot word,
	// whose top bit is set when every colour is taken.
	assign used_ext    = {1'b0, used_q};
	assign free_onehot = ~used_ext & (used_ext + {{MAX_COLORS{1'b0}}, 1'b1});

	always_comb begin
		free_color = '0;
		for (int unsigned i = 0; i <= MAX_COLORS; i++) begin
			if (free_onehot[i]) begin
				free_color = free_color | CW'(i);
			end
		end
	end

	// Used-colour bitmap and clearing sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			sweep_q <= '0;
		end else begin
			if (cmd.commit) begin
				used_q <= '0;
			end else if (cmd.mark && (32'(color_eff) < MAX_COLORS)) begin
				used_q <= used_q | (MAX_COLORS'(1) << color_eff[CBW-1:0]);
			end
			if (cmd.sweep_wr) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + 1'b1;
			end
		end
	end

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.load_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			color_q  <= COLOR_W'(free_color);
			vertex_q <= vid_q;
		end else if (cmd.load_read) begin
			color_q  <= COLOR_W'(color_eff);
			vertex_q <= vid_q;
		end
	end

	assign sts.sweep_last = (sweep_q == AW'(VERTEX_COUNT - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign color      = color_q;
	assign vertex_out = vertex_q;

endmodule

// ===== design/greedy_first_fit_coloring.sv =====
// Greedy first-fit colouring: each neighbour, assign or read item is accepted, then
// executed on the registered colour-store read; no new item is taken until it leaves execute.
// A result is registered at the end of its execute cycle and held until taken; an assign
// or read stays in execute while an earlier result is still waiting for its transfer.
// A clear item, and reset, sweep the colour store one vertex a cycle with input ready low.
// Reset is asynchronous, active low; it clears control and bitmap.
module greedy_first_fit_coloring import gffc_pkg::*; #(
	parameter int unsigned VERTEX_COUNT = 1024,
	parameter int unsigned MAX_COLORS   = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [ID_W-1:0]     neighbor_id,
	input  logic [ID_W-1:0]     vertex_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COLOR_W-1:0]  color,
	output logic [ID_W-1:0]     vertex_out
);

	cmd_t cmd;
	sts_t sts;

	// Sequencing of each item and of the clearing sweep.
	gffc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Colour store, bitmap and output register.
	gffc_dpath #(
		.VERTEX_COUNT (VERTEX_COUNT),
		.MAX_COLORS   (MAX_COLORS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.neighbor_id (neighbor_id),
		.vertex_id   (vertex_id),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.color       (color),
		.vertex_out  (vertex_out)
	);

`ifndef SYNTHESIS
	// An assign accepted with the output empty delivers its result once its execute state has run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_ASSIGN && !out_valid) |-> ##2 out_valid)
	else $error("assign transfer did not produce a result");

	// Neighbour and clear items produce no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (action == ACT_NEIGHBOR || action == ACT_CLEAR)
			&& !out_valid) |-> ##2 !out_valid)
	else $error("result produced by an item that has none");

	// A clear item starts the sweep, during which no item is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_CLEAR) |=> !in_ready)
	else $error("input taken at the start of a clearing sweep");
`endif

endmodule

// ===== tb/tb_greedy_first_fit_coloring.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the greedy first-fit colouring block.
// Drives neighbour, assign, clear and read transfers and checks each result.
// Depends on gffc_pkg and greedy_first_fit_coloring.
module tb_greedy_first_fit_coloring import gffc_pkg::*;;

	localparam int unsigned N_VERT      = 1024;
	localparam int unsigned PALETTE     = 64;
	localparam int unsigned RANDOM_ITEMS = 350;
	localparam int unsigned RAMP_TOP    = 20;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned STALL_LIMIT = 10000;
	localparam int unsigned PRINT_CAP   = 40;

	// One expected result: the colour and the vertex it belongs to.
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [ID_W-1:0]    vertex;
	} vertex_color_t;

	// Patterns that the result side steps through.
	typedef enum int unsigned {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = ACT_NEIGHBOR;
	logic [ID_W-1:0]     neighbor_id = '0;
	logic [ID_W-1:0]     vertex_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COLOR_W-1:0]  color;
	logic [ID_W-1:0]     vertex_out;

	// Shadow colouring state and the results still owed by the block.
	logic [COLOR_W-1:0] vertex_shade [N_VERT];
	logic [PALETTE-1:0] taken_mask = '0;
	vertex_color_t      owed_colors [$];
	vertex_color_t      owed_head;

	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left = 0;
	bit          steady_feed = 1'b0;
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned rx_left = 0;
	rx_mode_t    rx_mode = RX_STEADY;

	greedy_first_fit_coloring dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.neighbor_id(neighbor_id),
		.vertex_id  (vertex_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.color      (color),
		.vertex_out (vertex_out)
	);

	always #5 clk = ~clk;

	function automatic logic [ID_W-1:0] any_id();
		return ID_W'($urandom_range(0, N_VERT - 1));
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// Apply one accepted transfer to the shadow state and queue any result it owes.
	task automatic predict_coloring(input logic [ACTION_W-1:0] act,
			input logic [ID_W-1:0] nid, input logic [ID_W-1:0] vid);
		logic [COLOR_W-1:0] c;
		bit                 found;
		vertex_color_t      res;
		case (act)
			ACT_NEIGHBOR: begin
				c = (nid < N_VERT) ? vertex_shade[nid] : '0;
				if (c < PALETTE)
					taken_mask[c] = 1'b1;
			end
			ACT_ASSIGN: begin
				c = COLOR_W'(PALETTE);
				found = 1'b0;
				for (int i = 0; i < PALETTE; i++) begin
					if (!found && !taken_mask[i]) begin
						c = COLOR_W'(i);
						found = 1'b1;
					end
				end
				if (vid < N_VERT)
					vertex_shade[vid] = c;
				taken_mask = '0;
				res.color = c;
				res.vertex = vid;
				owed_colors = {owed_colors, res};
			end
			ACT_CLEAR: begin
				foreach (vertex_shade[i])
					vertex_shade[i] = '0;
			end
			default: begin
				res.color = (vid < N_VERT) ? vertex_shade[vid] : '0;
				res.vertex = vid;
				owed_colors = {owed_colors, res};
			end
		endcase
	endtask

	// Input monitor: every accepted transfer updates the shadow state.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_coloring(action, neighbor_id, vertex_id);
	end

	// Result checker: each accepted result is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (owed_colors.size() == 0) begin
				report_mismatch("result with none outstanding, vertex", vertex_out, 0);
			end else begin
				owed_head = owed_colors.pop_front();
				if (color !== owed_head.color)
					report_mismatch("colour", color, owed_head.color);
				if (vertex_out !== owed_head.vertex)
					report_mismatch("vertex", vertex_out, owed_head.vertex);
			end
		end
	end

	// Result side: a long hold-off when asked, otherwise a changing stall pattern.
	always @(negedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 120);
			end
			rx_left--;
			case (rx_mode)
				RX_STEADY: out_ready <= 1'b1;
				RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog on cycles in which no transfer happens on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one item until it is taken; without steady_feed, gaps may come between bursts.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] nid,
			input logic [ID_W-1:0] vid);
		int unsigned gap;
		if (!steady_feed && burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		neighbor_id <= nid;
		vertex_id <= vid;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every owed result has been taken.
	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_colors.size() != 0)
			@(negedge clk);
	endtask

	// Extremes of the ids, every action, an empty neighbour set and a bitmap kept over a clear.
	task automatic test_directed();
		send_item(ACT_READ, any_id(), '0);
		send_item(ACT_READ, any_id(), ID_W'(N_VERT - 1));
		send_item(ACT_ASSIGN, ID_W'(N_VERT - 1), ID_W'(5));
		send_item(ACT_NEIGHBOR, ID_W'(5), any_id());
		send_item(ACT_ASSIGN, '0, ID_W'(6));
		send_item(ACT_NEIGHBOR, ID_W'(5), any_id());
		send_item(ACT_NEIGHBOR, ID_W'(6), any_id());
		send_item(ACT_ASSIGN, any_id(), ID_W'(N_VERT - 1));
		send_item(ACT_READ, any_id(), ID_W'(N_VERT - 1));
		send_item(ACT_NEIGHBOR, ID_W'(N_VERT - 1), '0);
		send_item(ACT_NEIGHBOR, '0, ID_W'(N_VERT - 1));
		send_item(ACT_ASSIGN, any_id(), '0);
		send_item(ACT_NEIGHBOR, ID_W'(5), any_id());
		send_item(ACT_CLEAR, any_id(), any_id());
		send_item(ACT_READ, any_id(), ID_W'(N_VERT - 1));
		send_item(ACT_ASSIGN, any_id(), ID_W'(8));
		send_item(ACT_READ, any_id(), '0);
	endtask

	// Build a chain of vertices coloured 0 up to RAMP_TOP, each from a shuffled neighbour set.
	task automatic test_palette_ramp();
		logic [ID_W-1:0] order [N_VERT];
		int unsigned     perm [RAMP_TOP];
		int unsigned     j;
		int unsigned     tmp;
		logic [ID_W-1:0] swap_id;
		for (int i = 0; i < N_VERT; i++)
			order[i] = ID_W'(i);
		for (int i = N_VERT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap_id = order[i];
			order[i] = order[j];
			order[j] = swap_id;
		end
		// Start from an empty bitmap and an empty store.
		send_item(ACT_ASSIGN, any_id(), order[RAMP_TOP + 1]);
		send_item(ACT_CLEAR, any_id(), any_id());
		for (int k = 0; k <= RAMP_TOP; k++) begin
			for (int i = 0; i < k; i++)
				perm[i] = i;
			for (int i = k - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			for (int i = 0; i < k; i++) begin
				send_item(ACT_NEIGHBOR, order[perm[i]], any_id());
				if ($urandom_range(0, 7) == 0)
					send_item(ACT_NEIGHBOR, order[$urandom_range(0, k - 1)], any_id());
			end
			send_item(ACT_ASSIGN, any_id(), order[k]);
		end
		// A neighbour with the top colour of the chain leaves the lower colours free.
		send_item(ACT_NEIGHBOR, order[RAMP_TOP], any_id());
		send_item(ACT_ASSIGN, any_id(), order[RAMP_TOP + 2]);
		send_item(ACT_NEIGHBOR, order[RAMP_TOP], any_id());
		send_item(ACT_NEIGHBOR, order[0], any_id());
		send_item(ACT_ASSIGN, any_id(), order[RAMP_TOP + 3]);
		send_item(ACT_READ, any_id(), order[RAMP_TOP]);
		send_item(ACT_READ, any_id(), order[RAMP_TOP - 1]);
		wait_results();
	endtask

	// Result side holds off for a long stretch while items keep coming without gaps.
	task automatic test_backpressure();
		hold_asked++;
		steady_feed = 1'b1;
		for (int i = 0; i < 24; i++) begin
			case (i % 3)
				0:       send_item(ACT_NEIGHBOR, any_id(), any_id());
				1:       send_item(ACT_ASSIGN, any_id(), any_id());
				default: send_item(ACT_READ, any_id(), any_id());
			endcase
		end
		steady_feed = 1'b0;
		wait_results();
	endtask

	// Mostly neighbour sets followed by an assign, with reads, rare clears and noise.
	task automatic test_random();
		logic [ID_W-1:0] coloured [32];
		int unsigned     n_coloured;
		int unsigned     wr_slot;
		int unsigned     sent;
		int unsigned     pick;
		int unsigned     fan;
		logic [ID_W-1:0] vid;
		n_coloured = 0;
		wr_slot = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				fan = $urandom_range(0, 10);
				for (int i = 0; i < fan; i++) begin
					if (n_coloured != 0 && $urandom_range(0, 5) != 0)
						send_item(ACT_NEIGHBOR, coloured[$urandom_range(0, n_coloured - 1)],
							any_id());
					else
						send_item(ACT_NEIGHBOR, any_id(), any_id());
				end
				vid = any_id();
				send_item(ACT_ASSIGN, any_id(), vid);
				coloured[wr_slot] = vid;
				wr_slot = (wr_slot + 1) % 32;
				if (n_coloured < 32)
					n_coloured++;
				sent += fan + 1;
			end else if (pick < 85) begin
				if (n_coloured != 0 && $urandom_range(0, 1) == 0)
					send_item(ACT_READ, any_id(), coloured[$urandom_range(0, n_coloured - 1)]);
				else
					send_item(ACT_READ, any_id(), any_id());
				sent++;
			end else if (pick < 87) begin
				send_item(ACT_CLEAR, any_id(), any_id());
				sent++;
			end else begin
				case ($urandom_range(0, 2))
					0:       send_item(ACT_NEIGHBOR, any_id(), any_id());
					1:       send_item(ACT_ASSIGN, any_id(), any_id());
					default: send_item(ACT_READ, any_id(), any_id());
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		foreach (vertex_shade[i])
			vertex_shade[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_palette_ramp();
		test_backpressure();
		test_random();
		wait_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
